>>> rtl/nnfd_pkg.sv
// Shared types and constants for the nearest-neighbor fit downscaler.
// No dependencies; imported by the output buffer and the core.
package nnfd_pkg;

    // Field widths fixed by the register map and the pixel format
    localparam int PIXEL_W     = 32;
    localparam int SRC_DIM_W   = 13;
    localparam int CELLS_W     = 11;
    localparam int CELL_PX_W   = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam int DEFAULT_MAX_DIM = 4096;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_COLUMNS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_ROWS      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_PIXEL_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_PIXEL_HEIGHT = 3'd5;

    // One result word
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               row_end;
        logic               frame_end;
    } result_t;

    // Occupancy of the output buffer
    typedef struct packed {
        logic head_valid;
        logic spare_valid;
    } buf_status_t;

endpackage

>>> rtl/nnfd_out_skid.sv
// Two-entry output buffer (head register plus skid register) for result words.
// Depends on nnfd_pkg for result_t and buf_status_t.
module nnfd_out_skid (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  nnfd_pkg::result_t    push_word,
    output nnfd_pkg::result_t    head_word,
    output logic                 head_valid,
    input  logic                 head_ready,
    output nnfd_pkg::buf_status_t status
);
    import nnfd_pkg::*;

    result_t head_reg;
    result_t head_next;
    result_t spare_reg;
    result_t spare_next;
    logic    head_valid_reg;
    logic    head_valid_next;
    logic    spare_valid_reg;
    logic    spare_valid_next;
    logic    pop;

    assign pop = head_valid_reg && head_ready;

    // Refill head from the spare slot first, keep order
    always_comb
    begin
        head_next        = head_reg;
        spare_next       = spare_reg;
        head_valid_next  = head_valid_reg;
        spare_valid_next = spare_valid_reg;
        if (!head_valid_reg || pop)
        begin
            if (spare_valid_reg)
            begin
                head_next        = spare_reg;
                head_valid_next  = 1'b1;
                spare_next       = push_word;
                spare_valid_next = push;
            end
            else
            begin
                head_next       = push_word;
                head_valid_next = push;
            end
        end
        else if (push)
        begin
            spare_next       = push_word;
            spare_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg  <= head_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

    assign head_word          = head_reg;
    assign head_valid         = head_valid_reg;
    assign status.head_valid  = head_valid_reg;
    assign status.spare_valid = spare_valid_reg;

endmodule

>>> rtl/nearest_neighbor_fit_downscaler_core.sv
// Nearest-neighbor fit downscaler: selects source pixels for the target raster.
// Depends on nnfd_pkg and nnfd_out_skid.
// A selected pixel is registered into the output buffer's head or spare register, then leaves from the head.
// Throughput: one source pixel per clock while the buffer's spare slot is empty; accumulator add and compare per pixel.
// A two-word output buffer keeps accepting while one result waits downstream.
// Reset: registers 1,1,1,1,0,0; target 1x1; stream at the first pixel of a frame.
module nearest_neighbor_fit_downscaler_core #(
    parameter int MAX_DIM = nnfd_pkg::DEFAULT_MAX_DIM
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nnfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [nnfd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              src_valid,
    output logic                              src_ready,
    input  logic [nnfd_pkg::PIXEL_W-1:0]      pixel_in,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [nnfd_pkg::PIXEL_W-1:0]      pixel_out,
    output logic                              row_end,
    output logic                              frame_end
);
    import nnfd_pkg::*;

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int AW = 2 * DW + 1;
    localparam int PW = CELLS_W + CELL_PX_W;
    localparam int CW = (DW > PW) ? DW : PW;

    // Source size forced into 1..MAX_DIM
    function automatic logic [DW-1:0] clamp_src(input logic [SRC_DIM_W-1:0] v);
        logic [DW-1:0] r;
        if (v == '0)
            r = DW'(1);
        else if (32'(v) > 32'(MAX_DIM))
            r = DW'(MAX_DIM);
        else
            r = DW'(v);
        return r;
    endfunction

    // Target side: cells times cell pixels when known, never above source
    function automatic logic [DW-1:0] fit_dim(input logic [DW-1:0] s,
                                              input logic [PW-1:0] prod,
                                              input logic          known);
        logic [DW-1:0] r;
        if (known && (CW'(prod) < CW'(s)))
            r = DW'(prod);
        else
            r = s;
        if (r == '0)
            r = DW'(1);
        return r;
    endfunction

    // Configuration registers
    logic [SRC_DIM_W-1:0] src_w_reg, src_w_next;
    logic [SRC_DIM_W-1:0] src_h_reg, src_h_next;
    logic [CELLS_W-1:0]   disp_cols_reg, disp_cols_next;
    logic [CELLS_W-1:0]   disp_rows_reg, disp_rows_next;
    logic [CELL_PX_W-1:0] cell_w_reg, cell_w_next;
    logic [CELL_PX_W-1:0] cell_h_reg, cell_h_next;
    logic                 cfg_hit;

    // Derived sizes
    logic [DW-1:0] sw_reg, sw_next;
    logic [DW-1:0] sh_reg, sh_next;
    logic [DW-1:0] tw_reg, tw_next;
    logic [DW-1:0] th_reg, th_next;
    logic [PW-1:0] prod_w;
    logic [PW-1:0] prod_h;
    logic          cells_known;

    // Stream position
    logic [DW-1:0] src_col_reg, src_col_next;
    logic [DW-1:0] src_row_reg, src_row_next;
    logic [DW-1:0] dest_col_reg, dest_col_next;
    logic [DW-1:0] dest_row_reg, dest_row_next;
    logic [AW-1:0] col_pos_reg, col_pos_next;
    logic [AW-1:0] col_nxt_reg, col_nxt_next;
    logic [AW-1:0] row_pos_reg, row_pos_next;
    logic [AW-1:0] row_nxt_reg, row_nxt_next;

    logic        accept;
    logic        row_taken;
    logic        col_taken;
    logic        last_col;
    logic        last_row;
    logic        push;
    result_t     push_word;
    result_t     head_word;
    buf_status_t buf_status;

    assign cfg_ready = 1'b1;
    assign accept    = src_valid && src_ready;
    assign src_ready = !buf_status.spare_valid;

    // Register write decode
    always_comb
    begin
        src_w_next     = src_w_reg;
        src_h_next     = src_h_reg;
        disp_cols_next = disp_cols_reg;
        disp_rows_next = disp_rows_reg;
        cell_w_next    = cell_w_reg;
        cell_h_next    = cell_h_reg;
        cfg_hit        = 1'b0;
        if (cfg_valid)
        begin
            cfg_hit = 1'b1;
            unique case (cfg_index)
                REG_SOURCE_WIDTH:      src_w_next     = cfg_data;
                REG_SOURCE_HEIGHT:     src_h_next     = cfg_data;
                REG_DISPLAY_COLUMNS:   disp_cols_next = cfg_data[CELLS_W-1:0];
                REG_DISPLAY_ROWS:      disp_rows_next = cfg_data[CELLS_W-1:0];
                REG_CELL_PIXEL_WIDTH:  cell_w_next    = cfg_data[CELL_PX_W-1:0];
                REG_CELL_PIXEL_HEIGHT: cell_h_next    = cfg_data[CELL_PX_W-1:0];
                default:               cfg_hit        = 1'b0;
            endcase
        end
    end

    // Target size from the updated register set
    assign prod_w      = PW'(disp_cols_next) * PW'(cell_w_next);
    assign prod_h      = PW'(disp_rows_next) * PW'(cell_h_next);
    assign cells_known = (cell_w_next != '0) && (cell_h_next != '0) &&
                         (disp_cols_next != '0) && (disp_rows_next != '0);
    assign sw_next     = clamp_src(src_w_next);
    assign sh_next     = clamp_src(src_h_next);
    assign tw_next     = fit_dim(sw_next, prod_w, cells_known);
    assign th_next     = fit_dim(sh_next, prod_h, cells_known);

    // Selection tests
    assign row_taken = row_nxt_reg < (row_pos_reg + AW'(th_reg));
    assign col_taken = col_nxt_reg < (col_pos_reg + AW'(tw_reg));
    assign last_col  = (DW'(src_col_reg + DW'(1)) >= sw_reg) ||
                       (src_col_reg + DW'(1) == '0);
    assign last_row  = (DW'(src_row_reg + DW'(1)) >= sh_reg) ||
                       (src_row_reg + DW'(1) == '0);

    assign push                = accept && row_taken && col_taken;
    assign push_word.pixel     = pixel_in;
    assign push_word.row_end   = ({1'b0, dest_col_reg} + 1'b1) >= {1'b0, tw_reg};
    assign push_word.frame_end = push_word.row_end &&
                                 (({1'b0, dest_row_reg} + 1'b1) >= {1'b0, th_reg});

    // Position update per accepted pixel
    always_comb
    begin
        src_col_next  = src_col_reg;
        src_row_next  = src_row_reg;
        dest_col_next = dest_col_reg;
        dest_row_next = dest_row_reg;
        col_pos_next  = col_pos_reg;
        col_nxt_next  = col_nxt_reg;
        row_pos_next  = row_pos_reg;
        row_nxt_next  = row_nxt_reg;
        if (cfg_hit)
        begin
            src_col_next  = '0;
            src_row_next  = '0;
            dest_col_next = '0;
            dest_row_next = '0;
            col_pos_next  = '0;
            col_nxt_next  = '0;
            row_pos_next  = '0;
            row_nxt_next  = '0;
        end
        else if (accept)
        begin
            if (push)
            begin
                dest_col_next = dest_col_reg + DW'(1);
                col_nxt_next  = col_nxt_reg + AW'(sw_reg);
            end
            if (last_col)
            begin
                src_col_next  = '0;
                col_pos_next  = '0;
                col_nxt_next  = '0;
                dest_col_next = '0;
                if (last_row)
                begin
                    src_row_next  = '0;
                    row_pos_next  = '0;
                    row_nxt_next  = '0;
                    dest_row_next = '0;
                end
                else
                begin
                    if (row_taken)
                    begin
                        dest_row_next = dest_row_reg + DW'(1);
                        row_nxt_next  = row_nxt_reg + AW'(sh_reg);
                    end
                    src_row_next = src_row_reg + DW'(1);
                    row_pos_next = row_pos_reg + AW'(th_reg);
                end
            end
            else
            begin
                src_col_next = src_col_reg + DW'(1);
                col_pos_next = col_pos_reg + AW'(tw_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg     <= SRC_DIM_W'(1);
            src_h_reg     <= SRC_DIM_W'(1);
            disp_cols_reg <= CELLS_W'(1);
            disp_rows_reg <= CELLS_W'(1);
            cell_w_reg    <= '0;
            cell_h_reg    <= '0;
            sw_reg        <= DW'(1);
            sh_reg        <= DW'(1);
            tw_reg        <= DW'(1);
            th_reg        <= DW'(1);
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            dest_col_reg  <= '0;
            dest_row_reg  <= '0;
            col_pos_reg   <= '0;
            col_nxt_reg   <= '0;
            row_pos_reg   <= '0;
            row_nxt_reg   <= '0;
        end
        else
        begin
            src_w_reg     <= src_w_next;
            src_h_reg     <= src_h_next;
            disp_cols_reg <= disp_cols_next;
            disp_rows_reg <= disp_rows_next;
            cell_w_reg    <= cell_w_next;
            cell_h_reg    <= cell_h_next;
            if (cfg_hit)
            begin
                sw_reg <= sw_next;
                sh_reg <= sh_next;
                tw_reg <= tw_next;
                th_reg <= th_next;
            end
            src_col_reg  <= src_col_next;
            src_row_reg  <= src_row_next;
            dest_col_reg <= dest_col_next;
            dest_row_reg <= dest_row_next;
            col_pos_reg  <= col_pos_next;
            col_nxt_reg  <= col_nxt_next;
            row_pos_reg  <= row_pos_next;
            row_nxt_reg  <= row_nxt_next;
        end
    end

    // Result words leave through a two-entry buffer
    nnfd_out_skid u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .head_word  (head_word),
        .head_valid (res_valid),
        .head_ready (res_ready),
        .status     (buf_status)
    );

    assign pixel_out = head_word.pixel;
    assign row_end   = head_word.row_end;
    assign frame_end = head_word.frame_end;

`ifndef SYNTHESIS
    a_spare_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        buf_status.spare_valid |-> res_valid)
        else $error("spare word held with empty head");
    a_src_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        src_col_reg < sw_reg)
        else $error("source column beyond source width");
    a_dest_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (dest_col_reg <= tw_reg) && (tw_reg != '0) && (tw_reg <= sw_reg))
        else $error("target column or width out of range");
    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && frame_end) |-> row_end)
        else $error("frame end without row end");
`endif

endmodule

>>> dv/testbench.sv
// Self-checking testbench for nearest_neighbor_fit_downscaler_core.
// Depends on nnfd_pkg and the core RTL; each result word is checked against a scan predictor or a typed word.
// A directed walk comes first, then random settings under three idle mixes.
module testbench;
    import nnfd_pkg::*;

    // Indexes past the register map; writes to them must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

    localparam int MAX_EXTENT    = DEFAULT_MAX_DIM;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_WORDS   = 600;
    localparam int MAX_REPORTS   = 40;

    typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [CFG_INDEX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]    data;
        logic [PIXEL_W-1:0]       pixel;
        bit                       typed;
        result_t                  word;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   src_valid;
    logic                   src_ready;
    logic [PIXEL_W-1:0]     pixel_in;
    logic                   res_valid;
    logic                   res_ready;
    logic [PIXEL_W-1:0]     pixel_out;
    logic                   row_end;
    logic                   frame_end;

    // Register shadows
    logic [12:0] reg_src_w;
    logic [12:0] reg_src_h;
    logic [10:0] reg_cols;
    logic [10:0] reg_rows;
    logic [7:0]  reg_cell_w;
    logic [7:0]  reg_cell_h;

    // Scan state of the predictor
    logic [12:0] fit_w;
    logic [12:0] fit_h;
    logic [11:0] src_x;
    logic [11:0] src_y;
    logic [24:0] x_pos_acc;
    logic [24:0] x_next_acc;
    logic [24:0] y_pos_acc;
    logic [24:0] y_next_acc;
    logic [12:0] out_x;
    logic [12:0] out_y;

    result_t     expected_words[$];
    stim_row_t   stim_rows[$];
    bit          pixel_typed;
    result_t     typed_word;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatch_count;
    int          cycle_count;

    nearest_neighbor_fit_downscaler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .pixel_in  (pixel_in),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .pixel_out (pixel_out),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Source extent as the block sees it: zero reads as one, capped at the max
    function automatic logic [12:0] clamp_extent(input logic [12:0] v);
        if (v == 0)
        begin
            return 13'd1;
        end
        if (v > MAX_EXTENT)
        begin
            return 13'(MAX_EXTENT);
        end
        return v;
    endfunction

    task automatic restart_scan();
        src_x      = '0;
        src_y      = '0;
        x_pos_acc  = '0;
        x_next_acc = '0;
        y_pos_acc  = '0;
        y_next_acc = '0;
        out_x      = '0;
        out_y      = '0;
    endtask

    // Register write to a mapped index: update shadow, refit target, restart the frame
    task automatic apply_register_write(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        logic [31:0] sw;
        logic [31:0] sh;
        logic [31:0] tw;
        logic [31:0] th;
        case (idx)
            REG_SOURCE_WIDTH:      reg_src_w  = data;
            REG_SOURCE_HEIGHT:     reg_src_h  = data;
            REG_DISPLAY_COLUMNS:   reg_cols   = data[10:0];
            REG_DISPLAY_ROWS:      reg_rows   = data[10:0];
            REG_CELL_PIXEL_WIDTH:  reg_cell_w = data[7:0];
            REG_CELL_PIXEL_HEIGHT: reg_cell_h = data[7:0];
            default: ;
        endcase
        if (idx <= REG_CELL_PIXEL_HEIGHT)
        begin
            sw = 32'(clamp_extent(reg_src_w));
            sh = 32'(clamp_extent(reg_src_h));
            tw = sw;
            th = sh;
            if (reg_cell_w != 0 && reg_cell_h != 0 && reg_cols != 0 && reg_rows != 0)
            begin
                tw = 32'(reg_cols) * 32'(reg_cell_w);
                th = 32'(reg_rows) * 32'(reg_cell_h);
            end
            if (tw > sw)
            begin
                tw = sw;
            end
            if (th > sh)
            begin
                th = sh;
            end
            if (tw < 1)
            begin
                tw = 1;
            end
            if (th < 1)
            begin
                th = 1;
            end
            fit_w = tw[12:0];
            fit_h = th[12:0];
            restart_scan();
        end
    endtask

    // One source pixel: decide selection, then step the raster position
    task automatic advance_scan(input logic [PIXEL_W-1:0] pix, output bit hit,
                                output result_t word);
        logic [12:0] sw;
        logic [12:0] sh;
        bit          row_hit;
        bit          col_hit;
        bit          last_col;
        bit          last_row;
        sw       = clamp_extent(reg_src_w);
        sh       = clamp_extent(reg_src_h);
        row_hit  = y_next_acc < y_pos_acc + fit_h;
        col_hit  = x_next_acc < x_pos_acc + fit_w;
        last_col = (src_x + 1 >= sw);
        last_row = (src_y + 1 >= sh);
        hit      = row_hit && col_hit;
        word     = '0;
        if (hit)
        begin
            word.pixel     = pix;
            word.row_end   = (out_x + 1 >= fit_w);
            word.frame_end = word.row_end && (out_y + 1 >= fit_h);
            out_x          = out_x + 1;
            x_next_acc     = x_next_acc + sw;
        end
        if (last_col)
        begin
            src_x      = '0;
            x_pos_acc  = '0;
            x_next_acc = '0;
            out_x      = '0;
            if (last_row)
            begin
                restart_scan();
            end
            else
            begin
                if (row_hit)
                begin
                    out_y      = out_y + 1;
                    y_next_acc = y_next_acc + sh;
                end
                src_y     = src_y + 1;
                y_pos_acc = y_pos_acc + fit_h;
            end
        end
        else
        begin
            src_x     = src_x + 1;
            x_pos_acc = x_pos_acc + fit_w;
        end
    endtask

    // Print one mismatch line (capped) and count it
    task automatic log_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("%0t %s: got %h want %h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // Sample all three channels at the rising edge, in a fixed order
    always @(posedge clk)
    begin : observe
        bit      hit;
        result_t word;
        result_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_register_write(cfg_index, cfg_data);
            end
            if (src_valid && src_ready)
            begin
                advance_scan(pixel_in, hit, word);
                if (pixel_typed)
                begin
                    expected_words.push_back(typed_word);
                end
                else if (hit)
                begin
                    expected_words.push_back(word);
                end
            end
            if (res_valid && res_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    log_mismatch("unexpected word", pixel_out, '0);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (pixel_out !== want.pixel)
                    begin
                        log_mismatch("pixel_out", pixel_out, want.pixel);
                    end
                    if (row_end !== want.row_end)
                    begin
                        log_mismatch("row_end", 32'(row_end), 32'(want.row_end));
                    end
                    if (frame_end !== want.frame_end)
                    begin
                        log_mismatch("frame_end", 32'(frame_end), 32'(want.frame_end));
                    end
                end
            end
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Called at a falling edge; returns at the falling edge after the accept
    task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input bit typed,
                              input result_t word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_typed = typed;
        typed_word  = word;
        src_valid  <= 1'b1;
        pixel_in   <= pix;
        do
        begin
            @(posedge clk);
        end
        while (!src_ready);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stop sending, let every expected word come out, then let the pipe settle
    task automatic wait_until_drained();
        src_valid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic add_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row       = '{kind: ROW_WRITE, default: '0};
        row.index = idx;
        row.data  = data;
        stim_rows.push_back(row);
    endtask

    task automatic add_pixel(input logic [PIXEL_W-1:0] pix, input bit typed,
                             input bit re, input bit fe);
        stim_row_t row;
        row                = '{kind: ROW_PIXEL, default: '0};
        row.pixel          = pix;
        row.typed          = typed;
        row.word.pixel     = pix;
        row.word.row_end   = re;
        row.word.frame_end = fe;
        stim_rows.push_back(row);
    endtask

    function automatic logic [12:0] pick_extent();
        int r;
        r = $urandom_range(99);
        if (r < 78)
        begin
            return 13'($urandom_range(1, 10));
        end
        if (r < 84)
        begin
            return 13'd0;
        end
        if (r < 90)
        begin
            return 13'(MAX_EXTENT);
        end
        if (r < 95)
        begin
            return 13'($urandom_range(MAX_EXTENT + 1, 8191));
        end
        return 13'($urandom_range(11, MAX_EXTENT - 1));
    endfunction

    function automatic logic [12:0] pick_cells();
        int r;
        r = $urandom_range(99);
        if (r < 70)
        begin
            return 13'($urandom_range(1, 3));
        end
        if (r < 78)
        begin
            return 13'd0;
        end
        if (r < 86)
        begin
            return 13'd1024;
        end
        return 13'($urandom_range(0, 8191));
    endfunction

    function automatic logic [12:0] pick_cell_px();
        int r;
        r = $urandom_range(99);
        if (r < 22)
        begin
            return 13'd0;
        end
        if (r < 82)
        begin
            return 13'($urandom_range(1, 3));
        end
        if (r < 90)
        begin
            return 13'd255;
        end
        return 13'($urandom_range(0, 8191));
    endfunction

    function automatic logic [PIXEL_W-1:0] random_pixel();
        int r;
        r = $urandom_range(99);
        if (r < 5)
        begin
            return '0;
        end
        if (r < 10)
        begin
            return '1;
        end
        return $urandom();
    endfunction

    // New random setting; returns how many source pixels to stream under it
    task automatic program_setting(output int count);
        int frame;
        if ($urandom_range(9) != 0)
        begin
            cfg_write(REG_SOURCE_WIDTH, pick_extent());
        end
        if ($urandom_range(9) != 0)
        begin
            cfg_write(REG_SOURCE_HEIGHT, pick_extent());
        end
        if ($urandom_range(9) != 0)
        begin
            cfg_write(REG_DISPLAY_COLUMNS, pick_cells());
        end
        if ($urandom_range(9) != 0)
        begin
            cfg_write(REG_DISPLAY_ROWS, pick_cells());
        end
        if ($urandom_range(9) != 0)
        begin
            cfg_write(REG_CELL_PIXEL_WIDTH, pick_cell_px());
        end
        if ($urandom_range(9) != 0)
        begin
            cfg_write(REG_CELL_PIXEL_HEIGHT, pick_cell_px());
        end
        if ($urandom_range(9) == 0)
        begin
            cfg_write($urandom_range(1) ? REG_UNUSED_HI : REG_UNUSED_LO,
                      13'($urandom_range(0, 8191)));
        end
        // Small frames run whole, often wrapping; larger ones run for 40 to 160 pixels
        frame = int'(clamp_extent(reg_src_w)) * int'(clamp_extent(reg_src_h));
        if (frame <= 64)
        begin
            count = frame * $urandom_range(1, 3);
            if ($urandom_range(2) == 0)
            begin
                count += $urandom_range(0, frame - 1);
            end
        end
        else
        begin
            count = $urandom_range(40, 160);
        end
    endtask

    initial
    begin : stimulus
        int  send_pct_by_phase[3];
        int  recv_pct_by_phase[3];
        int  phase_words;
        int  count;
        bit  streaming;
        send_pct_by_phase = '{35, 60, 0};
        recv_pct_by_phase = '{60, 35, 0};
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        src_valid      = 1'b0;
        pixel_in       = '0;
        res_ready      = 1'b0;
        pixel_typed    = 1'b0;
        typed_word     = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle_pct  = send_pct_by_phase[0];
        recv_idle_pct  = recv_pct_by_phase[0];
        streaming      = 1'b0;

        // Predictor starts from the reset values
        reg_src_w  = 13'd1;
        reg_src_h  = 13'd1;
        reg_cols   = 11'd1;
        reg_rows   = 11'd1;
        reg_cell_w = 8'd0;
        reg_cell_h = 8'd0;
        fit_w      = 13'd1;
        fit_h      = 13'd1;
        restart_scan();

        // Out of reset: 1x1 source, every pixel ends its row and frame
        add_pixel(32'h0000_0000, 1'b1, 1'b1, 1'b1);
        add_pixel(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        add_pixel(32'hA5C3_5A3C, 1'b1, 1'b1, 1'b1);
        // 3x2 copy; a write to an unused index mid-frame must not restart it
        add_write(REG_SOURCE_WIDTH, 13'd3);
        add_write(REG_SOURCE_HEIGHT, 13'd2);
        add_pixel(32'h1111_0001, 1'b1, 1'b0, 1'b0);
        add_pixel(32'h2222_0002, 1'b1, 1'b0, 1'b0);
        add_write(REG_UNUSED_LO, 13'h1FFF);
        add_pixel(32'h3333_0003, 1'b1, 1'b1, 1'b0);
        add_pixel(32'h4444_0004, 1'b1, 1'b0, 1'b0);
        add_pixel(32'h5555_0005, 1'b1, 1'b0, 1'b0);
        add_pixel(32'h6666_0006, 1'b1, 1'b1, 1'b1);
        // 4x2 source fitted into one cell of 2x1 pixels
        add_write(REG_CELL_PIXEL_WIDTH, 13'd2);
        add_write(REG_CELL_PIXEL_HEIGHT, 13'd1);
        add_write(REG_SOURCE_WIDTH, 13'd4);
        for (int i = 0; i < 8; i++)
        begin
            add_pixel($urandom(), 1'b0, 1'b0, 1'b0);
        end
        // Unknown cell size, zero width and oversize height: 1 x max copy
        add_write(REG_CELL_PIXEL_WIDTH, 13'd0);
        add_write(REG_DISPLAY_COLUMNS, 13'h1FFF);
        add_write(REG_DISPLAY_ROWS, 13'd0);
        add_write(REG_SOURCE_WIDTH, 13'd0);
        add_write(REG_SOURCE_HEIGHT, 13'h1FFF);
        add_pixel(32'hDEAD_BEEF, 1'b1, 1'b1, 1'b0);
        add_pixel(32'h0F0F_F0F0, 1'b1, 1'b1, 1'b0);
        add_pixel(32'h8000_0001, 1'b1, 1'b1, 1'b0);
        add_write(REG_UNUSED_HI, 13'h0AAA);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed walk
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_WRITE)
            begin
                if (streaming)
                begin
                    wait_until_drained();
                    streaming = 1'b0;
                end
                cfg_write(stim_rows[i].index, stim_rows[i].data);
            end
            else
            begin
                send_pixel(stim_rows[i].pixel, stim_rows[i].typed, stim_rows[i].word);
                streaming = 1'b1;
            end
        end

        // Random settings under each idle mix
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = send_pct_by_phase[phase];
            recv_idle_pct = recv_pct_by_phase[phase];
            phase_words   = 0;
            while (phase_words < PHASE_WORDS)
            begin
                wait_until_drained();
                program_setting(count);
                for (int k = 0; k < count; k++)
                begin
                    // Occasional hold-off mid-frame until the output side is empty
                    if (k == count / 2 && $urandom_range(3) == 0)
                    begin
                        wait_until_drained();
                    end
                    send_pixel(random_pixel(), 1'b0, '0);
                end
                phase_words += count;
            end
        end

        wait_until_drained();
        if (mismatch_count == 0 && expected_words.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
